// File: hw/rtl/fxa_pkg.sv
// Shared types and codes for the Q24.8 fixed-point ALU.
// No dependencies.
`timescale 1ns / 1ps
package fxa_pkg;
   typedef enum logic [3:0] {
      ACT_ADD = 4'd0, ACT_SUB = 4'd1, ACT_MUL = 4'd2, ACT_DIV = 4'd3,
      ACT_CMP = 4'd4, ACT_MIN = 4'd5, ACT_MAX = 4'd6, ACT_INC = 4'd7,
      ACT_DEC = 4'd8, ACT_FROM_INT = 4'd9, ACT_TO_INT = 4'd10
   } action_type;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_SAT = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;

   localparam int WORD_W = 32;

   typedef struct packed {
      logic [3:0]               action;
      logic signed [WORD_W-1:0] operand_a;
      logic signed [WORD_W-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] result;
      logic                     less;
      logic                     equal;
      logic                     greater;
      logic [1:0]               status;
   } rsp_type;
endpackage

// File: hw/rtl/fixed_point_q24_8_alu.sv
// Q24.8 signed fixed-point ALU: top level with the pipelined datapath.
// Depends on fxa_pkg and fxa_div.
//
// One word is accepted per cycle while the result side is not stalled, and results
// leave in order through the stage 1 register, the divider stages and the output
// register. The divider resolves one quotient bit per stage. Every action
// travels through the same pipe, so any mix of actions streams at full rate.
// A stall on the result side freezes the whole pipe.
`timescale 1ns / 1ps
module fixed_point_q24_8_alu
   import fxa_pkg::*;
#(
   parameter int FRAC_BITS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   localparam int W  = WORD_W;
   localparam int NW = W + FRAC_BITS;
   localparam int TW = 4 + 2 * W + 3 + 2;

   // tag carried along the divider: action, fast result, flags, status, sign
   typedef struct packed {
      logic [3:0]   action;
      logic [W-1:0] res;
      logic [W-1:0] mul_lo;
      logic         lt;
      logic         eq;
      logic         gt;
      logic [1:0]   st;
   } tag_type;

   logic adv;
   assign adv = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // ---- stage 1: magnitudes, 32x32 product, add paths
   logic signed [W-1:0] a, b;
   assign a = req_data.operand_a;
   assign b = req_data.operand_b;
   logic [W-1:0] ma, mb;
   assign ma = a[W-1] ? W'(-a) : W'(a);
   assign mb = b[W-1] ? W'(-b) : W'(b);

   logic lt, eq, gt;
   assign lt = a < b;
   assign eq = a == b;
   assign gt = a > b;

   logic signed [W:0] sum, dif, inc, dec;
   assign sum = {a[W-1], a} + {b[W-1], b};
   assign dif = {a[W-1], a} - {b[W-1], b};
   assign inc = {a[W-1], a} + (W+1)'(1);
   assign dec = {a[W-1], a} - (W+1)'(1);

   localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

   function automatic logic [W+1:0] sat_w(input logic signed [W:0] v);
      if (v[W] != v[W-1]) return {ST_SAT, v[W] ? MINV : MAXV};
      return {ST_OK, v[W-1:0]};
   endfunction

   logic [W-1:0] fast_res;
   logic [1:0]   fast_st;
   always_comb begin
      logic [W+1:0] t;
      t = '0;
      fast_res = '0;
      fast_st = ST_OK;
      case (req_data.action)
         ACT_ADD: t = sat_w(sum);
         ACT_SUB: t = sat_w(dif);
         ACT_INC: t = sat_w(inc);
         ACT_DEC: t = sat_w(dec);
         default: t = '0;
      endcase
      case (req_data.action)
         ACT_ADD, ACT_SUB, ACT_INC, ACT_DEC: begin
            fast_res = t[W-1:0];
            fast_st = t[W+1:W];
         end
         ACT_MIN: fast_res = lt ? a : b;
         ACT_MAX: fast_res = gt ? a : b;
         ACT_FROM_INT: fast_res = W'(a <<< FRAC_BITS);
         ACT_TO_INT: fast_res = W'(a >>> FRAC_BITS);
         ACT_DIV: fast_st = (mb == '0) ? ST_DIV0 : ST_OK;
         default: fast_res = '0;
      endcase
   end

   logic          s1_v_ff;
   tag_type       s1_tag_ff;
   logic [2*W-1:0] s1_prod_ff;
   logic [W-1:0]  s1_ma_ff, s1_mb_ff;
   logic          s1_neg_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (adv) s1_v_ff <= req_valid;
      if (adv) begin
         s1_tag_ff  <= '{req_data.action, fast_res, '0, lt, eq, gt, fast_st};
         s1_prod_ff <= ma * mb;
         s1_ma_ff   <= ma;
         s1_mb_ff   <= mb;
         s1_neg_ff  <= a[W-1] ^ b[W-1];
      end
   end

   // ---- stage 2: round and saturate product
   logic [2*W-FRAC_BITS-1:0] ps;
   logic [2*W:0] prh;
   assign prh = {1'b0, s1_prod_ff} + ((2*W+1)'(1) << (FRAC_BITS - 1));
   assign ps = prh[2*W-1:FRAC_BITS];
   logic ovf_m;
   assign ovf_m = prh[2*W] || (s1_neg_ff ? ({1'b0, ps} > {1'b0, MINV})
                                         : ({1'b0, ps} > {1'b0, MAXV}));
   logic [W-1:0] mres;
   assign mres = ovf_m ? (s1_neg_ff ? MINV : MAXV)
                       : (s1_neg_ff ? W'(-ps[W-1:0]) : ps[W-1:0]);

   tag_type tag2;
   always_comb begin
      tag2 = s1_tag_ff;
      tag2.mul_lo = mres;
      if (s1_tag_ff.action == ACT_MUL) tag2.st = ovf_m ? ST_SAT : ST_OK;
   end

   logic [TW-1:0] dtag_out;
   logic [NW-1:0] q;
   logic [W:0]    r;
   logic [W-1:0]  d;
   logic          dv;
   logic          neg_d;

   // divider tag: one extra bit for sign
   fxa_div #(.NW(NW), .DW(W), .TW(TW + 1)) u_div (
      .clock(clock), .reset(reset), .adv(adv),
      .n_in({s1_ma_ff, {FRAC_BITS{1'b0}}}), .d_in(s1_mb_ff),
      .tag_in({s1_neg_ff, tag2}), .v_in(s1_v_ff),
      .q_out(q), .r_out(r), .d_out(d), .tag_out({neg_d, dtag_out}), .v_out(dv)
   );

   tag_type tg;
   assign tg = tag_type'(dtag_out);

   // ---- stage 3: divide rounding and result select
   logic [NW:0] qr;
   assign qr = {1'b0, q} + (NW+1)'((r >= ({1'b0, d} - r)) ? 1 : 0);
   logic ovf_d;
   assign ovf_d = neg_d ? (qr > (NW+1)'(MINV)) : (qr > (NW+1)'(MAXV));
   logic [W-1:0] dres;
   assign dres = ovf_d ? (neg_d ? MINV : MAXV)
                       : (neg_d ? W'(-qr[W-1:0]) : qr[W-1:0]);

   rsp_type out_in;
   always_comb begin
      out_in.result  = tg.res;
      out_in.less    = tg.lt;
      out_in.equal   = tg.eq;
      out_in.greater = tg.gt;
      out_in.status  = tg.st;
      case (tg.action)
         ACT_MUL: out_in.result = tg.mul_lo;
         ACT_DIV: begin
            if (tg.st == ST_DIV0) out_in.result = '0;
            else begin
               out_in.result = dres;
               out_in.status = ovf_d ? ST_SAT : ST_OK;
            end
         end
         default: out_in.result = tg.res;
      endcase
   end

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= dv;
      if (adv) rsp_data_ff <= out_in;
   end
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

// File: hw/rtl/fxa_div.sv
// Pipelined restoring divider stage: one quotient bit per pipeline stage.
// Depends on nothing; instantiated by the top level.
`timescale 1ns / 1ps
module fxa_div #(
   parameter int NW = 40,
   parameter int DW = 32,
   parameter int TW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic [NW-1:0] n_in,
   input  logic [DW-1:0] d_in,
   input  logic [TW-1:0] tag_in,
   input  logic          v_in,
   output logic [NW-1:0] q_out,
   output logic [DW:0]   r_out,
   output logic [DW-1:0] d_out,
   output logic [TW-1:0] tag_out,
   output logic          v_out
);
   // stage k holds remainder, shifting numerator/quotient word, divisor, tag
   logic [DW:0]   r_ff   [NW+1];
   logic [NW-1:0] nq_ff  [NW+1];
   logic [DW-1:0] d_ff   [NW+1];
   logic [TW-1:0] tag_ff [NW+1];
   logic          v_ff   [NW+1];

   always_comb begin
      r_ff[0]   = '0;
      nq_ff[0]  = n_in;
      d_ff[0]   = d_in;
      tag_ff[0] = tag_in;
      v_ff[0]   = v_in;
   end

   for (genvar k = 0; k < NW; k++) begin : g_st
      logic [DW+1:0] sh;
      logic [DW+1:0] df;
      logic [DW:0] r_reg;
      logic [NW-1:0] nq_reg;
      logic [DW-1:0] d_reg;
      logic [TW-1:0] t_reg;
      logic v_reg;
      assign sh = {r_ff[k], nq_ff[k][NW-1]};
      assign df = sh - {2'b00, d_ff[k]};
      always_ff @(posedge clock) begin
         if (reset) v_reg <= 1'b0;
         else if (adv) v_reg <= v_ff[k];
         if (adv) begin
            r_reg  <= df[DW+1] ? sh[DW:0] : df[DW:0];
            nq_reg <= {nq_ff[k][NW-2:0], ~df[DW+1]};
            d_reg  <= d_ff[k];
            t_reg  <= tag_ff[k];
         end
      end
      always_comb begin
         r_ff[k+1]   = r_reg;
         nq_ff[k+1]  = nq_reg;
         d_ff[k+1]   = d_reg;
         tag_ff[k+1] = t_reg;
         v_ff[k+1]   = v_reg;
      end
   end

   assign q_out   = nq_ff[NW];
   assign r_out   = r_ff[NW];
   assign d_out   = d_ff[NW];
   assign tag_out = tag_ff[NW];
   assign v_out   = v_ff[NW];
endmodule

// File: hw/rtl/fxa_checker.sv
// Port-level checks for the fixed-point ALU.
// Depends on fxa_pkg; bound to fixed_point_q24_8_alu.
`timescale 1ns / 1ps
module fxa_checker
   import fxa_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_data.less, rsp_data.equal, rsp_data.greater}) == 1)
      else $error("compare flags not one-hot");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != 2'd3)
      else $error("bad status code");
endmodule

bind fixed_point_q24_8_alu fxa_checker u_fxa_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

// File: sim/fixed_point_q24_8_alu_test.sv
// Self-checking bench for the Q24.8 fixed-point ALU: random and directed words,
// an in-bench arithmetic predictor and an in-order result check.
// Depends on fxa_pkg and the fixed_point_q24_8_alu RTL.
`timescale 1ns / 1ps
module fixed_point_q24_8_alu_test;
   import fxa_pkg::*;

   localparam int FB = 8;
   localparam int LIMIT = 400000;
   localparam longint WMAX = 64'sd2147483647;
   localparam longint WMIN = -64'sd2147483648;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_words[$];
   rsp_type expected_rsp[$];
   int  errors = 0;
   int  cycles = 0;
   bit  quiet = 1'b0;      // no idling near the end
   bit  hold_rsp = 1'b0;   // long receiver hold-off request
   bit  feeding = 1'b1;
   bit  req_taken = 1'b0;  // input word accepted at the last rising edge
   int  send_gap = 0;
   int  rsp_gap = 0;
   int  hold_cnt = 0;

   fixed_point_q24_8_alu dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] clamp(input logic signed [127:0] v, inout logic [1:0] st);
      if (v > WMAX) begin
         st = ST_SAT;
         return WMAX[31:0];
      end
      if (v < WMIN) begin
         st = ST_SAT;
         return WMIN[31:0];
      end
      return v[31:0];
   endfunction

   // Exact rounding: magnitude, half added, then floor; sign applied after.
   function automatic logic signed [127:0] round_div(input logic signed [127:0] n,
                                                     input logic signed [127:0] d);
      logic [127:0] mn, md, q, r;
      logic neg;
      neg = (n < 0) != (d < 0);
      mn = (n < 0) ? -n : n;
      md = (d < 0) ? -d : d;
      q = mn / md;
      r = mn % md;
      if (r >= md - r) q = q + 1;
      return neg ? -$signed(q) : $signed(q);
   endfunction

   function automatic rsp_type alu_predict(input req_type w);
      rsp_type o;
      logic signed [127:0] a, b;
      logic [1:0] st;
      a = w.operand_a;
      b = w.operand_b;
      st = ST_OK;
      o = '0;
      o.less = a < b;
      o.equal = a == b;
      o.greater = a > b;
      case (w.action)
         ACT_ADD: o.result = clamp(a + b, st);
         ACT_SUB: o.result = clamp(a - b, st);
         ACT_MUL: o.result = clamp(round_div(a * b, 128'sd256), st);
         ACT_DIV: begin
            if (b == 0) st = ST_DIV0;
            else o.result = clamp(round_div(a <<< FB, b), st);
         end
         ACT_CMP: o.result = '0;
         ACT_MIN: o.result = o.less ? w.operand_a : w.operand_b;
         ACT_MAX: o.result = o.greater ? w.operand_a : w.operand_b;
         ACT_INC: o.result = clamp(a + 1, st);
         ACT_DEC: o.result = clamp(a - 1, st);
         ACT_FROM_INT: o.result = w.operand_a << FB;
         ACT_TO_INT: o.result = w.operand_a >>> FB;
         default: o.result = '0;
      endcase
      o.status = st;
      return o;
   endfunction

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 9))
         0: return 32'h7fffffff - $urandom_range(0, 3);
         1: return 32'h80000000 + $urandom_range(0, 3);
         2: return $urandom_range(0, 3) - 1;
         3, 4: return $signed($urandom_range(0, 8191)) - 4096;
         5: return $signed({$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)});
         default: return $urandom;
      endcase
   endfunction

   task automatic add_word(input logic [3:0] act, input logic [31:0] x, input logic [31:0] y);
      req_type w;
      w.action = act;
      w.operand_a = x;
      w.operand_b = y;
      pending_words.push_back(w);
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            pending_words.pop_front();
         end
         if (!req_valid || req_taken) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (feeding && pending_words.size() > 0) begin
               req_valid <= 1'b1;
               req_data <= pending_words[0];
               if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 5);
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_gap <= $urandom_range(0, 4);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor: expectation queued on accept, result checked on accept
   always @(posedge clock) begin
      cycles <= cycles + 1;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) expected_rsp.push_back(alu_predict(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t unexpected word actual %h", $time, rsp_data);
               errors <= errors + 1;
            end else begin
               if (rsp_data !== expected_rsp[0]) begin
                  $display("%0t mismatch expected %h actual %h", $time, expected_rsp[0], rsp_data);
                  errors <= errors + 1;
               end
               expected_rsp.pop_front();
            end
         end
      end
      if (cycles > LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      logic [31:0] ext[6];
      ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'hffffffff, 32'h100};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // directed: each action on extremes, ties, zero divisor, unused codes
      for (int act = 0; act < 11; act++) begin
         add_word(4'(act), ext[act % 6], ext[(act + 1) % 6]);
      end
      add_word(ACT_DIV, 32'h00000500, 32'h0);
      add_word(ACT_DIV, 32'h7fffffff, 32'h00000001);
      add_word(ACT_MUL, 32'h80000000, 32'h80000000);
      add_word(ACT_MUL, 32'hffffff80, 32'h00000001);
      add_word(ACT_MIN, 32'h12345678, 32'h12345678);
      add_word(ACT_MAX, 32'h80000000, 32'h80000000);
      add_word(ACT_INC, 32'h7fffffff, 32'h0);
      add_word(ACT_DEC, 32'h80000000, 32'h0);
      add_word(ACT_TO_INT, 32'hffffff01, 32'h0);
      add_word(4'd11, 32'h5, 32'h5);
      add_word(4'd15, 32'hffffffff, 32'h0);
      add_word(ACT_SUB, 32'h80000000, 32'h00000001);
      // receiver holds off while the sender keeps offering
      hold_rsp = 1'b1;
      for (int i = 0; i < 80; i++) begin
         add_word(4'($urandom_range(0, 10)), rand_operand(), rand_operand());
      end
      while (hold_cnt < 200) begin
         @(posedge clock);
         hold_cnt++;
      end
      hold_rsp = 1'b0;
      wait (pending_words.size() == 0);
      // sender pauses until the pipe drains
      feeding = 1'b0;
      wait (expected_rsp.size() == 0);
      feeding = 1'b1;
      for (int i = 0; i < 1800; i++) begin
         add_word($urandom_range(0, 20) == 0 ? 4'($urandom_range(11, 15))
                                             : 4'($urandom_range(0, 10)),
                  rand_operand(), $urandom_range(0, 15) == 0 ? 32'h0 : rand_operand());
      end
      wait (pending_words.size() < 300);
      quiet = 1'b1;
      wait (pending_words.size() == 0 && !req_valid);
      wait (expected_rsp.size() == 0);
      repeat (60) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

// File: fixed_point_q24_8_alu.f
hw/rtl/fxa_pkg.sv
hw/rtl/fxa_div.sv
hw/rtl/fixed_point_q24_8_alu.sv
hw/rtl/fxa_checker.sv
sim/fixed_point_q24_8_alu_test.sv
